// ===== src/tlpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpc_pkg
// Shared types, phase codes, lamp patterns and register map for the traffic
// light controller with pedestrian button.
// ----------------------------------------------------------------------------
package tlpc_pkg;

    localparam int TIMER_BITS   = 16;
    localparam int FLASH_GROUPS = 10;
    localparam int FLASH_W      = 5;
    localparam int DUR_W        = 16;
    localparam int LAMP_W       = 8;
    localparam int APB_AW       = 5;
    localparam int APB_DW       = 32;

    typedef enum logic [3:0] {
        PH_ALL_RED    = 4'd0,
        PH_NS_GREEN   = 4'd1,
        PH_NS_YELLOW  = 4'd2,
        PH_NS_CLEAR   = 4'd3,
        PH_EW_GREEN   = 4'd4,
        PH_EW_YELLOW  = 4'd5,
        PH_EW_CLEAR   = 4'd6,
        PH_WALK       = 4'd7,
        PH_FLASH_ON_A = 4'd8,
        PH_FLASH_OFF  = 4'd9,
        PH_FLASH_ON_B = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        REG_ALL_RED = 3'd0,
        REG_GREEN   = 3'd1,
        REG_YELLOW  = 3'd2,
        REG_CLEAR   = 3'd3,
        REG_WALK    = 3'd4,
        REG_FLASH   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [DUR_W-1:0] all_red_ticks;
        logic [DUR_W-1:0] green_ticks;
        logic [DUR_W-1:0] yellow_ticks;
        logic [DUR_W-1:0] clear_ticks;
        logic [DUR_W-1:0] walk_ticks;
        logic [DUR_W-1:0] flash_ticks;
    } cfg_t;

    typedef logic [LAMP_W-1:0] lamp_t;

    // lamp bit positions
    localparam int L_NSG = 0;
    localparam int L_NSY = 1;
    localparam int L_NSR = 2;
    localparam int L_EWG = 3;
    localparam int L_EWY = 4;
    localparam int L_EWR = 5;
    localparam int L_WG  = 6;
    localparam int L_WR  = 7;

    localparam lamp_t LAMPS_ALL_RED   = 8'b1010_0100;
    localparam lamp_t LAMPS_WALK      = 8'b0110_0100;
    localparam lamp_t LAMPS_NS_GREEN  = 8'b1010_0001;
    localparam lamp_t LAMPS_NS_YELLOW = 8'b1010_0010;
    localparam lamp_t LAMPS_EW_GREEN  = 8'b1000_1100;
    localparam lamp_t LAMPS_EW_YELLOW = 8'b1001_0100;

    function automatic logic [DUR_W-1:0] duration_of(input phase_t ph, input cfg_t cfg);
        logic [DUR_W-1:0] d;
        d = cfg.flash_ticks;
        unique case (ph)
            PH_ALL_RED:                d = cfg.all_red_ticks;
            PH_NS_GREEN, PH_EW_GREEN:  d = cfg.green_ticks;
            PH_NS_YELLOW, PH_EW_YELLOW: d = cfg.yellow_ticks;
            PH_NS_CLEAR, PH_EW_CLEAR:  d = cfg.clear_ticks;
            PH_WALK:                   d = cfg.walk_ticks;
            default:                   d = cfg.flash_ticks;
        endcase
        return d;
    endfunction

endpackage

// ===== src/tlpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tlpc_cfg_regs
// APB register file holding the six interval durations.
// ----------------------------------------------------------------------------
module tlpc_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tlpc_pkg::APB_AW-1:0] paddr,
    input  logic [tlpc_pkg::APB_DW-1:0] pwdata,
    output logic [tlpc_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output tlpc_pkg::cfg_t              cfg
);
    import tlpc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.all_red_ticks <= 16'd10;
            cfg_reg.green_ticks   <= 16'd20;
            cfg_reg.yellow_ticks  <= 16'd3;
            cfg_reg.clear_ticks   <= 16'd5;
            cfg_reg.walk_ticks    <= 16'd15;
            cfg_reg.flash_ticks   <= 16'd1;
        end else if (wr_en) begin
            case (idx)
                REG_ALL_RED: cfg_reg.all_red_ticks <= pwdata[DUR_W-1:0];
                REG_GREEN:   cfg_reg.green_ticks   <= pwdata[DUR_W-1:0];
                REG_YELLOW:  cfg_reg.yellow_ticks  <= pwdata[DUR_W-1:0];
                REG_CLEAR:   cfg_reg.clear_ticks   <= pwdata[DUR_W-1:0];
                REG_WALK:    cfg_reg.walk_ticks    <= pwdata[DUR_W-1:0];
                REG_FLASH:   cfg_reg.flash_ticks   <= pwdata[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            REG_ALL_RED: prdata = APB_DW'(cfg_reg.all_red_ticks);
            REG_GREEN:   prdata = APB_DW'(cfg_reg.green_ticks);
            REG_YELLOW:  prdata = APB_DW'(cfg_reg.yellow_ticks);
            REG_CLEAR:   prdata = APB_DW'(cfg_reg.clear_ticks);
            REG_WALK:    prdata = APB_DW'(cfg_reg.walk_ticks);
            REG_FLASH:   prdata = APB_DW'(cfg_reg.flash_ticks);
            default:     prdata = '0;
        endcase
    end

endmodule

// ===== src/tlpc_phase_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlpc_phase_ctrl
// Phase sequencer: interval timer, request latch, flash counter and lamps.
// Advances one tick per accepted input beat.
// ----------------------------------------------------------------------------
module tlpc_phase_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic            ped_button,
    input  tlpc_pkg::cfg_t  cfg,
    output tlpc_pkg::lamp_t lamps
);
    import tlpc_pkg::*;

    localparam int CMP_W = ((TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W) + 1;

    phase_t                phase_reg, phase_next;
    phase_t                resume_reg, resume_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [FLASH_W-1:0]    flash_reg, flash_next;
    logic                  latch_reg, latch_next;
    lamp_t                 lamp_reg, lamp_next;

    logic                  checked;
    logic                  latch_eff;
    logic                  req;
    logic                  ended;
    logic [CMP_W-1:0]      timer_inc;
    logic [CMP_W-1:0]      dur_ext;
    logic [FLASH_W:0]      flash_inc;
    lamp_t                 ybit;

    assign lamps = lamp_reg;

    always_comb begin
        checked   = (phase_reg == PH_ALL_RED) || (phase_reg == PH_NS_GREEN) ||
                    (phase_reg == PH_NS_YELLOW) || (phase_reg == PH_NS_CLEAR) ||
                    (phase_reg == PH_EW_GREEN) || (phase_reg == PH_EW_YELLOW) ||
                    (phase_reg == PH_EW_CLEAR);
        latch_eff = latch_reg || (checked && ped_button);
        req       = checked && latch_eff;
        timer_inc = CMP_W'(timer_reg) + CMP_W'(1);
        dur_ext   = CMP_W'(duration_of(phase_reg, cfg));
        // a zero duration compares as already reached
        ended     = (timer_inc >= dur_ext) || (&timer_reg);
        flash_inc = (FLASH_W+1)'(flash_reg) + (FLASH_W+1)'(1);
        ybit      = '0;
        if (resume_reg == PH_EW_GREEN) begin
            ybit[L_EWY] = 1'b1;
        end else begin
            ybit[L_NSY] = 1'b1;
        end

        phase_next  = phase_reg;
        resume_next = resume_reg;
        flash_next  = flash_reg;
        lamp_next   = lamp_reg;
        latch_next  = latch_eff;
        timer_next  = timer_inc[TIMER_BITS-1:0];

        if (ended) begin
            latch_next = 1'b0;
            timer_next = '0;
            unique case (phase_reg)
                PH_ALL_RED, PH_NS_YELLOW, PH_EW_YELLOW, PH_NS_CLEAR, PH_EW_CLEAR: begin
                    if (req) begin
                        resume_next = phase_reg;
                        phase_next  = PH_WALK;
                        lamp_next   = LAMPS_WALK;
                    end else begin
                        unique case (phase_reg)
                            PH_ALL_RED: begin
                                phase_next = PH_NS_GREEN;
                                lamp_next  = LAMPS_NS_GREEN;
                            end
                            PH_NS_YELLOW: begin
                                phase_next       = PH_NS_CLEAR;
                                lamp_next[L_NSY] = 1'b0;
                                lamp_next[L_NSR] = 1'b1;
                            end
                            PH_EW_YELLOW: begin
                                phase_next       = PH_EW_CLEAR;
                                lamp_next[L_EWY] = 1'b0;
                                lamp_next[L_EWR] = 1'b1;
                            end
                            PH_NS_CLEAR: begin
                                phase_next = PH_EW_GREEN;
                                lamp_next  = LAMPS_EW_GREEN;
                            end
                            default: begin
                                phase_next = PH_ALL_RED;
                                lamp_next  = LAMPS_ALL_RED;
                            end
                        endcase
                    end
                end
                PH_NS_GREEN, PH_EW_GREEN: begin
                    if (req) begin
                        resume_next = phase_reg;
                        flash_next  = '0;
                        phase_next  = PH_FLASH_ON_A;
                        lamp_next   = (phase_reg == PH_NS_GREEN) ? LAMPS_NS_YELLOW
                                                                  : LAMPS_EW_YELLOW;
                    end else if (phase_reg == PH_NS_GREEN) begin
                        phase_next = PH_NS_YELLOW;
                        lamp_next  = LAMPS_NS_YELLOW;
                    end else begin
                        phase_next = PH_EW_YELLOW;
                        lamp_next  = LAMPS_EW_YELLOW;
                    end
                end
                PH_WALK: begin
                    phase_next = resume_reg;
                    if (resume_reg == PH_NS_GREEN) begin
                        lamp_next = LAMPS_NS_GREEN;
                    end else if (resume_reg == PH_EW_GREEN) begin
                        lamp_next = LAMPS_EW_GREEN;
                    end else begin
                        // repeated interval keeps the walk's reds
                        lamp_next[L_WG] = 1'b0;
                        lamp_next[L_WR] = 1'b1;
                    end
                end
                PH_FLASH_ON_A: begin
                    phase_next = PH_FLASH_OFF;
                    lamp_next  = lamp_reg & ~ybit;
                end
                PH_FLASH_OFF: begin
                    phase_next = PH_FLASH_ON_B;
                    lamp_next  = lamp_reg | ybit;
                end
                PH_FLASH_ON_B: begin
                    if (flash_inc >= (FLASH_W+1)'(FLASH_GROUPS)) begin
                        flash_next = '0;
                        phase_next = PH_WALK;
                        lamp_next  = LAMPS_WALK;
                    end else begin
                        flash_next = flash_inc[FLASH_W-1:0];
                        phase_next = PH_FLASH_ON_A;
                    end
                end
                default: begin
                    phase_next  = PH_ALL_RED;
                    resume_next = PH_ALL_RED;
                    flash_next  = '0;
                    lamp_next   = LAMPS_ALL_RED;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_ALL_RED;
            resume_reg <= PH_ALL_RED;
            timer_reg  <= '0;
            flash_reg  <= '0;
            latch_reg  <= 1'b0;
            lamp_reg   <= LAMPS_ALL_RED;
        end else if (step) begin
            phase_reg  <= phase_next;
            resume_reg <= resume_next;
            timer_reg  <= timer_next;
            flash_reg  <= flash_next;
            latch_reg  <= latch_next;
            lamp_reg   <= lamp_next;
        end
    end

    a_walk_needs_reds: assert property (@(posedge aclk) disable iff (!aresetn)
        lamp_reg[L_WG] |-> (lamp_reg[L_NSR] && lamp_reg[L_EWR] && !lamp_reg[L_WR]))
        else $error("walk lamp on without both reds");

    a_no_cross_green: assert property (@(posedge aclk) disable iff (!aresetn)
        !(lamp_reg[L_NSG] && lamp_reg[L_EWG]))
        else $error("both roads green");

    a_walk_lamps: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_WALK) |-> (lamp_reg == LAMPS_WALK))
        else $error("walk phase with wrong lamps");

    a_flash_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (FLASH_W+1)'(flash_reg) < (FLASH_W+1)'(FLASH_GROUPS))
        else $error("flash group count out of range");

    a_latch_only_when_checked: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !checked) |=> !latch_reg)
        else $error("request latched outside a timed interval");

endmodule

// ===== src/traffic_light_ped_controller_top.sv =====
// ----------------------------------------------------------------------------
// traffic_light_ped_controller_top
// Traffic light controller with pedestrian button, one input beat per tick.
// ----------------------------------------------------------------------------
// Each accepted input beat is one time tick: it carries the sampled pedestrian
// button and produces one result beat with the eight lamps shown during that
// tick. A new beat is accepted every cycle in which s_ready is high; the phase
// sequencer updates its timer, request latch and lamps in the same cycle and the
// lamps land in the output register, so throughput is one beat per clock unless
// a low m_ready holds a result; m_valid rises in the cycle after input accept.
// s_ready only drops while a result is held by a low m_ready. Durations are set
// over the APB port and should be written while no ticks are in flight.
module traffic_light_ped_controller_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_ped_button,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_ns_go,
    output logic                        m_ns_amber,
    output logic                        m_ns_red,
    output logic                        m_ew_go,
    output logic                        m_ew_amber,
    output logic                        m_ew_red,
    output logic                        m_walk_green,
    output logic                        m_walk_red,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tlpc_pkg::APB_AW-1:0] paddr,
    input  logic [tlpc_pkg::APB_DW-1:0] pwdata,
    output logic [tlpc_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import tlpc_pkg::*;

    cfg_t  cfg;
    lamp_t lamps;
    lamp_t out_reg;
    logic  m_valid_reg;
    logic  step;

    assign s_ready = !m_valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    tlpc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tlpc_phase_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .ped_button (s_ped_button),
        .cfg        (cfg),
        .lamps      (lamps)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // lamps shown during this tick, before the sequencer moves on
    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= lamps;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ns_go      = out_reg[L_NSG];
    assign m_ns_amber   = out_reg[L_NSY];
    assign m_ns_red     = out_reg[L_NSR];
    assign m_ew_go      = out_reg[L_EWG];
    assign m_ew_amber   = out_reg[L_EWY];
    assign m_ew_red     = out_reg[L_EWR];
    assign m_walk_green = out_reg[L_WG];
    assign m_walk_red   = out_reg[L_WR];

endmodule
